>>> src/dcfc_pkg.sv
`default_nettype none
package dcfc_pkg;

  // Frame constants
  localparam logic [7:0] HOST_BYTE   = 8'h51;
  localparam logic [7:0] LEN_FLAG    = 8'h80;
  localparam logic [7:0] RX_SEED     = 8'h50;
  localparam logic [6:0] ADDR_RESET  = 7'h37;
  localparam int         MAX_PAYLOAD_DEF = 127;

  typedef enum logic [1:0] {
    KIND_TX_BYTE   = 2'd0,
    KIND_RX_DATA   = 2'd1,
    KIND_RX_STATUS = 2'd2
  } kind_t;

  typedef enum logic [2:0] {
    ST_OK        = 3'd0,
    ST_BAD_ADDR  = 3'd1,
    ST_BAD_LEN   = 3'd2,
    ST_BAD_SUM   = 3'd3,
    ST_TRUNCATED = 3'd4
  } status_t;

  typedef struct packed {
    kind_t       kind;
    logic [7:0]  out_byte;
    status_t     status;
    logic        end_of_run;
  } res_t;

endpackage
`default_nettype wire

>>> src/dcfc_if.sv
`default_nettype none
interface dcfc_in_if;
  logic       valid;
  logic       ready;
  logic       mode;
  logic [7:0] data_byte;
  logic [6:0] frame_length;
  logic       last_byte;

  modport source (output valid, mode, data_byte, frame_length, last_byte, input ready);
  modport sink   (input valid, mode, data_byte, frame_length, last_byte, output ready);
endinterface

interface dcfc_out_if;
  logic       valid;
  logic       ready;
  logic [1:0] kind;
  logic [7:0] out_byte;
  logic [2:0] status;
  logic       end_of_run;

  modport source (output valid, kind, out_byte, status, end_of_run, input ready);
  modport sink   (input valid, kind, out_byte, status, end_of_run, output ready);
endinterface
`default_nettype wire

>>> src/ddc_ci_frame_codec_core.sv
`default_nettype none
// The first result of an item is registered and valid in the cycle after the item's transfer.
// Throughput: 1 item per cycle while each item yields at most one result and the
//   output is ready; an item yielding 2 or 3 results holds the input off while the
//   three-entry result buffer drains one result per cycle while the output is ready.
// Reset (rst, synchronous): clears the tx/rx frame state and the result buffer,
//   and loads device_address with 0x37.
module ddc_ci_frame_codec_core #(
  parameter int MAX_PAYLOAD = dcfc_pkg::MAX_PAYLOAD_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        cfg_we,
  input  wire logic [6:0]  cfg_wdata,
  dcfc_in_if.sink          in_ch,
  dcfc_out_if.source       out_ch
);

  typedef enum logic [2:0] {
    PH_ADDR   = 3'd0,
    PH_LEN    = 3'd1,
    PH_DATA   = 3'd2,
    PH_SUM    = 3'd3,
    PH_IGNORE = 3'd4
  } rx_phase_t;

  localparam logic [6:0] MAX_LEN = 7'(MAX_PAYLOAD);

  logic [6:0]      device_address;
  logic            tx_active, tx_active_next;
  logic [7:0]      tx_xor, tx_xor_next;
  logic [6:0]      tx_remaining, tx_remaining_next;
  rx_phase_t       rx_phase, rx_phase_next;
  logic [7:0]      rx_xor, rx_xor_next;
  logic [6:0]      rx_remaining, rx_remaining_next;
  logic [6:0]      rx_limit, rx_limit_next;

  dcfc_pkg::res_t  res [3];
  dcfc_pkg::res_t  res_next [3];
  logic [1:0]      cnt;
  logic [1:0]      cnt_next;

  logic            in_fire;
  logic            pop;

  assign pop         = out_ch.valid && out_ch.ready;
  assign in_ch.ready = (cnt == 2'd0) || (cnt == 2'd1 && out_ch.ready);
  assign in_fire     = in_ch.valid && in_ch.ready;

  assign out_ch.valid      = (cnt != 2'd0);
  assign out_ch.kind       = res[0].kind;
  assign out_ch.out_byte   = res[0].out_byte;
  assign out_ch.status     = res[0].status;
  assign out_ch.end_of_run = res[0].end_of_run;

  // Work out the results and the next frame state for the item at the input
  always_comb begin
    logic [6:0] len;
    logic [7:0] lb;
    logic [7:0] x;
    logic [6:0] rem;
    logic [7:0] b;
    rx_phase_t  ph;
    logic [1:0] idx;
    logic       done;

    tx_active_next    = tx_active;
    tx_xor_next       = tx_xor;
    tx_remaining_next = tx_remaining;
    rx_phase_next     = rx_phase;
    rx_xor_next       = rx_xor;
    rx_remaining_next = rx_remaining;
    rx_limit_next     = rx_limit;
    for (int i = 0; i < 3; i++) begin
      res_next[i] = '0;
    end
    idx  = 2'd0;
    done = 1'b0;
    b    = in_ch.data_byte;
    len  = '0;
    lb   = '0;
    x    = '0;
    rem  = '0;
    ph   = rx_phase;

    // Flush a checksum owed by a one-byte frame
    if (tx_active && tx_remaining == 7'd0) begin
      res_next[idx] = '{dcfc_pkg::KIND_TX_BYTE, tx_xor, dcfc_pkg::ST_OK, 1'b0};
      idx = idx + 2'd1;
      tx_active_next = 1'b0;
      if (!in_ch.mode) begin
        done = 1'b1;
      end
    end

    if (!done && !in_ch.mode) begin
      if (!tx_active) begin
        // Open a frame: host byte, length byte, first payload byte
        len = (in_ch.frame_length == 7'd0) ? 7'd1 : in_ch.frame_length;
        len = (len > MAX_LEN) ? MAX_LEN : len;
        lb  = dcfc_pkg::LEN_FLAG | {1'b0, len};
        res_next[0] = '{dcfc_pkg::KIND_TX_BYTE, dcfc_pkg::HOST_BYTE, dcfc_pkg::ST_OK, 1'b0};
        res_next[1] = '{dcfc_pkg::KIND_TX_BYTE, lb, dcfc_pkg::ST_OK, 1'b0};
        res_next[2] = '{dcfc_pkg::KIND_TX_BYTE, b, dcfc_pkg::ST_OK, 1'b0};
        idx = 2'd3;
        tx_xor_next       = {device_address, 1'b0} ^ dcfc_pkg::HOST_BYTE ^ lb ^ b;
        tx_active_next    = 1'b1;
        tx_remaining_next = in_ch.last_byte ? 7'd0 : len - 7'd1;
      end else begin
        // Pass the byte through and close the frame when counted out
        res_next[idx] = '{dcfc_pkg::KIND_TX_BYTE, b, dcfc_pkg::ST_OK, 1'b0};
        idx = idx + 2'd1;
        x   = tx_xor ^ b;
        rem = tx_remaining - 7'd1;
        tx_xor_next       = x;
        tx_remaining_next = rem;
        if (rem == 7'd0 || in_ch.last_byte) begin
          res_next[idx] = '{dcfc_pkg::KIND_TX_BYTE, x, dcfc_pkg::ST_OK, 1'b0};
          idx = idx + 2'd1;
          tx_active_next    = 1'b0;
          tx_remaining_next = 7'd0;
        end
      end
    end else if (!done) begin
      case (rx_phase)
        PH_ADDR: begin
          rx_limit_next = (in_ch.frame_length > MAX_LEN) ? MAX_LEN : in_ch.frame_length;
          if (b != {device_address, 1'b0}) begin
            res_next[idx] = '{dcfc_pkg::KIND_RX_STATUS, 8'd0, dcfc_pkg::ST_BAD_ADDR, 1'b0};
            idx = idx + 2'd1;
            ph  = PH_IGNORE;
          end else begin
            rx_xor_next = dcfc_pkg::RX_SEED ^ b;
            ph = PH_LEN;
          end
        end
        PH_LEN: begin
          len = b[6:0];
          if (len > rx_limit) begin
            res_next[idx] = '{dcfc_pkg::KIND_RX_STATUS, 8'd0, dcfc_pkg::ST_BAD_LEN, 1'b0};
            idx = idx + 2'd1;
            ph  = PH_IGNORE;
          end else begin
            rx_xor_next       = rx_xor ^ b;
            rx_remaining_next = len;
            ph = (len != 7'd0) ? PH_DATA : PH_SUM;
          end
        end
        PH_DATA: begin
          res_next[idx] = '{dcfc_pkg::KIND_RX_DATA, b, dcfc_pkg::ST_OK, 1'b0};
          idx = idx + 2'd1;
          rx_xor_next = rx_xor ^ b;
          rem = rx_remaining - 7'd1;
          rx_remaining_next = rem;
          if (rem == 7'd0) begin
            ph = PH_SUM;
          end
        end
        PH_SUM: begin
          x = rx_xor ^ b;
          rx_xor_next = x;
          res_next[idx] = '{dcfc_pkg::KIND_RX_STATUS, 8'd0,
                            (x == 8'd0) ? dcfc_pkg::ST_OK : dcfc_pkg::ST_BAD_SUM, 1'b0};
          idx = idx + 2'd1;
          ph  = PH_IGNORE;
        end
        default: begin
          ph = PH_IGNORE;
        end
      endcase
      // Flag an early end and rearm for the next address byte
      if (in_ch.last_byte) begin
        if (ph != PH_IGNORE) begin
          res_next[idx] = '{dcfc_pkg::KIND_RX_STATUS, 8'd0, dcfc_pkg::ST_TRUNCATED, 1'b0};
          idx = idx + 2'd1;
        end
        ph = PH_ADDR;
      end
      rx_phase_next = ph;
    end

    // Mark the final result of the item
    if (idx != 2'd0) begin
      res_next[idx - 2'd1].end_of_run = 1'b1;
    end
    cnt_next = idx;
  end

  // Hold frame state and the result buffer
  always_ff @(posedge clk) begin
    if (rst) begin
      device_address <= dcfc_pkg::ADDR_RESET;
      tx_active      <= 1'b0;
      tx_xor         <= '0;
      tx_remaining   <= '0;
      rx_phase       <= PH_ADDR;
      rx_xor         <= '0;
      rx_remaining   <= '0;
      rx_limit       <= '0;
      cnt            <= 2'd0;
    end else begin
      if (cfg_we) begin
        device_address <= cfg_wdata;
      end
      if (in_fire) begin
        tx_active    <= tx_active_next;
        tx_xor       <= tx_xor_next;
        tx_remaining <= tx_remaining_next;
        rx_phase     <= rx_phase_next;
        rx_xor       <= rx_xor_next;
        rx_remaining <= rx_remaining_next;
        rx_limit     <= rx_limit_next;
        cnt          <= cnt_next;
      end else if (pop) begin
        cnt <= cnt - 2'd1;
      end
    end
  end

  // Load new results, or advance the buffer on each output transfer
  always_ff @(posedge clk) begin
    if (in_fire) begin
      res[0] <= res_next[0];
      res[1] <= res_next[1];
      res[2] <= res_next[2];
    end else if (pop) begin
      res[0] <= res[1];
      res[1] <= res[2];
    end
  end

`ifndef SYNTHESIS
  // Opening a tx frame fills the whole buffer
  assert property (@(posedge clk) disable iff (rst)
    (in_fire && !in_ch.mode && !tx_active) |=> (cnt == 2'd3))
    else $error("tx frame open did not yield three results");

  // The last buffered result closes its item
  assert property (@(posedge clk) disable iff (rst)
    (cnt == 2'd1) |-> out_ch.end_of_run)
    else $error("last pending result lacks end_of_run");

  // Only status results carry a nonzero status
  assert property (@(posedge clk) disable iff (rst)
    (out_ch.valid && out_ch.kind != dcfc_pkg::KIND_RX_STATUS) |->
      (out_ch.status == dcfc_pkg::ST_OK))
    else $error("nonzero status on a byte result");

  // An item is taken only when the buffer is empty or empties this cycle
  assert property (@(posedge clk) disable iff (rst)
    in_fire |-> (cnt == 2'd0 || (cnt == 2'd1 && pop)))
    else $error("item taken over pending results");
`endif

endmodule
`default_nettype wire
